>>> hdl/epse_pkg.sv
// Package for the entropy pool SHA-256 extractor: beat types, constants
// and SHA-256 helper functions. No dependencies.
`timescale 1ns / 1ps
package epse_pkg;

  localparam logic [31:0] MIX_MULT = 32'd1234567891;
  localparam logic [5:0]  DIGEST_BYTES = 6'd32;

  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] entropy_word;
    logic [31:0] frame_word;
    logic [31:0] tick_word;
    logic [5:0]  byte_count;
  } epse_in_t;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       last_byte;
  } epse_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic feed;       // apply the captured feed word to the pool
    logic load;       // load message schedule and working variables
    logic round;      // run one compression round
    logic finish;     // add the initial hash into the state
    logic shift_out;  // advance to the next digest byte
  } epse_cmd_t;

  typedef logic [7:0][31:0] word8_t;

  localparam word8_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] ROUND_K = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

>>> hdl/epse_datapath.sv
// Datapath: pool registers, counters, SHA-256 round unit and digest shifter.
// Depends on epse_pkg.
`timescale 1ns / 1ps
module epse_datapath import epse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  epse_in_t    item,
  input  logic        capture,
  input  epse_cmd_t   cmd,
  input  logic [5:0]  round_idx,
  output logic [7:0]  digest_byte
);

  epse_in_t    item_r;
  word8_t      pool_r, pool_nxt;
  logic [31:0] feed_cnt_r, feed_cnt_nxt;
  logic [31:0] req_cnt_r, req_cnt_nxt;
  logic [15:0][31:0] w_r, w_nxt;
  word8_t      v_r, v_nxt;
  logic [31:0] mix_mul_r;
  logic        mix_ph_r;

  logic [31:0] mix, s0, s1, t1, t2, wnew, req_next;
  logic [31:0] a, b, c, d, e, f, g, h;

  assign req_next = req_cnt_r + 32'd1;
  assign mix = mix_mul_r ^ (mix_mul_r >> 16);
  assign {h, g, f, e, d, c, b, a} = v_r;
  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = w_r[0] + s0 + w_r[9] + s1;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[round_idx] + w_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign digest_byte = v_r[0][31:24];

  always_comb begin
    pool_nxt = pool_r;
    feed_cnt_nxt = feed_cnt_r;
    req_cnt_nxt = req_cnt_r;
    w_nxt = w_r;
    v_nxt = v_r;
    if (cmd.feed) begin
      pool_nxt[feed_cnt_r[2:0] + 3'd1] = pool_r[feed_cnt_r[2:0] + 3'd1] + mix;
      feed_cnt_nxt = feed_cnt_r + 32'd1;
    end
    if (cmd.load) begin
      // The load happens in the accepting cycle, so the header comes from the beat itself.
      req_cnt_nxt = req_next;
      w_nxt[0] = bswap(feed_cnt_r);
      w_nxt[1] = bswap(item.frame_word);
      w_nxt[2] = bswap(item.tick_word);
      w_nxt[3] = bswap(req_next);
      for (int i = 0; i < 8; i++) w_nxt[4 + i] = bswap(pool_r[i]);
      w_nxt[12] = 32'h80000000;
      w_nxt[13] = 32'h0;
      w_nxt[14] = 32'h0;
      w_nxt[15] = 32'h00000180;
      v_nxt = INIT_H;
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = wnew;
      v_nxt = {g, f, e, d + t1, c, b, a, t1 + t2};
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) v_nxt[i] = v_r[i] + INIT_H[i];
    end
    if (cmd.shift_out) begin
      v_nxt[0] = {v_r[0][23:0], v_r[1][31:24]};
      for (int i = 1; i < 7; i++) v_nxt[i] = {v_r[i][23:0], v_r[i + 1][31:24]};
      v_nxt[7] = {v_r[7][23:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= '0;
      feed_cnt_r <= '0;
      req_cnt_r <= '0;
      mix_ph_r <= 1'b0;
    end else begin
      pool_r <= pool_nxt;
      feed_cnt_r <= feed_cnt_nxt;
      req_cnt_r <= req_cnt_nxt;
      mix_ph_r <= capture;
    end
    if (capture) item_r <= item;
    // The product is registered in the cycle after capture, before the feed step.
    if (mix_ph_r) mix_mul_r <= (item_r.entropy_word ^ pool_r[feed_cnt_r[2:0]]) * MIX_MULT;
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

endmodule

>>> hdl/epse_ctrl.sv
// Controller state machine: sequences feed, hash rounds and byte output.
// Depends on epse_pkg.
`timescale 1ns / 1ps
module epse_ctrl import epse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  epse_in_t   item,
  input  logic       out_stall,
  output logic       in_ready,
  output logic       capture,
  output epse_cmd_t  cmd,
  output logic [5:0] round_idx,
  output logic       out_valid,
  output logic       out_last
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_FEED   = 6'b000100,
    S_ROUND  = 6'b001000,
    S_FINISH = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] left_r, left_nxt;
  logic       fire_out;

  assign in_ready = (state_r == S_IDLE);
  assign capture = in_fire;
  assign round_idx = cnt_r;
  assign out_valid = (state_r == S_OUT);
  assign out_last = (left_r == 6'd1);
  assign fire_out = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    left_nxt = left_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (item.operation == OP_FEED) begin
            state_nxt = S_MUL;
          end else if (item.byte_count != 6'd0) begin
            cmd.load = 1'b1;
            cnt_nxt = 6'd0;
            left_nxt = (item.byte_count > DIGEST_BYTES) ? DIGEST_BYTES : item.byte_count;
            state_nxt = S_ROUND;
          end
        end
      end
      S_MUL: state_nxt = S_FEED;
      S_FEED: begin
        cmd.feed = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (fire_out) begin
          cmd.shift_out = 1'b1;
          left_nxt = left_r - 6'd1;
          if (out_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      left_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

>>> hdl/entropy_pool_sha256_extractor_unit.sv
// Top level of the entropy pool SHA-256 extractor.
// Depends on epse_pkg, epse_ctrl and epse_datapath.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one beat per item.
//   A feed beat mixes entropy_word into the eight-word pool and gives no
//   output; it passes through capture, registered multiply and pool update.
//   An extract beat with a nonzero byte_count (saturated to 32) hashes the
//   counters, frame and tick words and the pool with one SHA-256 block, one
//   round per cycle on a single round unit: 64 rounds, then the final
//   addition, then byte_count output beats, first digest byte first,
//   last_byte set on the final one. An extract with byte_count 0 gives no
//   output. The block holds one item at a time: in_stall is high while busy.
//   out_stall holds the current byte in place until it is taken.
//   Reset (rst_n low, synchronous) clears the pool and both counters.
`timescale 1ns / 1ps
module entropy_pool_sha256_extractor_unit import epse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  epse_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output epse_out_t out_data
);

  logic       in_ready, in_fire, capture, last;
  epse_cmd_t  cmd;
  logic [5:0] round_idx;
  logic [7:0] digest_byte;

  assign in_stall = !in_ready;
  assign in_fire = in_valid && in_ready;
  assign out_data.random_byte = digest_byte;
  assign out_data.last_byte = last;

  epse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .item(in_data),
    .out_stall(out_stall), .in_ready(in_ready), .capture(capture), .cmd(cmd),
    .round_idx(round_idx), .out_valid(out_valid), .out_last(last)
  );

  epse_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .item(in_data), .capture(capture), .cmd(cmd),
    .round_idx(round_idx), .digest_byte(digest_byte)
  );

endmodule

>>> hdl/epse_checker.sv
// Port-level checker for the extractor, bound to the top level.
// Depends on epse_pkg.
`timescale 1ns / 1ps
module epse_checker import epse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input epse_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input epse_out_t out_data
);

  // No new item is taken while a result beat is pending.
  a_no_accept_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during output");

  // A feed never leads to a result beat right after it.
  a_feed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.operation == OP_FEED) |=> !out_valid)
    else $error("feed produced output");

  // After the last byte is taken the block returns to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_byte) |=> !out_valid && !in_stall)
    else $error("extract did not end after last byte");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

endmodule

bind entropy_pool_sha256_extractor_unit epse_checker u_epse_checker (.*);

>>> verif/tb_entropy_pool_sha256_extractor_unit.sv
// Testbench for the entropy pool SHA-256 extractor: drives feed and extract
// beats, predicts the digest bytes with its own pool and SHA-256 code.
// Depends on epse_pkg and entropy_pool_sha256_extractor_unit.
`timescale 1ns / 1ps
module tb_entropy_pool_sha256_extractor_unit;
  import epse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  epse_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  epse_out_t out_data;

  entropy_pool_sha256_extractor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [31:0] pool_model [8];
  logic [31:0] feeds_seen;
  logic [31:0] requests_seen;
  epse_out_t   digest_bytes_due [$];

  int mismatches = 0;
  int bytes_checked = 0;
  int feeds_sent = 0;
  int extracts_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 58;
  bit hold_off = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] le_word(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // One SHA-256 compression over the 48-byte message plus padding.
  function automatic logic [255:0] digest_of_message(logic [31:0] msg [12]);
    logic [31:0] w [64];
    logic [31:0] k [64];
    logic [31:0] hv [8];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    for (int i = 0; i < 12; i++) w[i] = msg[i];
    w[12] = 32'h80000000;
    w[13] = '0;
    w[14] = '0;
    w[15] = 32'd384;
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + k[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
            hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + h};
  endfunction

  // Updates the pool model for one accepted beat and queues its digest bytes.
  task automatic predict_beat(epse_in_t item);
    logic [31:0] mixed;
    logic [31:0] msg [12];
    logic [255:0] dig;
    int n;
    if (item.operation == OP_FEED) begin
      mixed = (item.entropy_word ^ pool_model[feeds_seen[2:0]]) * MIX_MULT;
      mixed = mixed ^ (mixed >> 16);
      feeds_seen = feeds_seen + 1;
      pool_model[feeds_seen[2:0]] = pool_model[feeds_seen[2:0]] + mixed;
      return;
    end
    if (item.byte_count == 0) return;
    n = (item.byte_count > DIGEST_BYTES) ? 32 : int'(item.byte_count);
    requests_seen = requests_seen + 1;
    msg[0] = le_word(feeds_seen);
    msg[1] = le_word(item.frame_word);
    msg[2] = le_word(item.tick_word);
    msg[3] = le_word(requests_seen);
    for (int i = 0; i < 8; i++) msg[4 + i] = le_word(pool_model[i]);
    dig = digest_of_message(msg);
    for (int i = 0; i < n; i++)
      digest_bytes_due.push_back('{dig[255 - 8*i -: 8], i == n - 1});
  endtask

  // Directed rows; the first extract after reset hashes an all-zero pool.
  typedef struct {
    epse_in_t item;
    bit       typed;
    epse_out_t first_byte;
  } stim_row_t;

  stim_row_t directed_rows [$];

  // Valid stays high from one beat to the next unless the sender idles.
  task automatic send_beat(epse_in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(item);
    if (item.operation == OP_FEED) feeds_sent++;
    else extracts_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digest_bytes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic epse_in_t random_item(bit extract);
    epse_in_t it;
    it.operation    = extract ? OP_EXTRACT : OP_FEED;
    it.entropy_word = $urandom;
    it.frame_word   = $urandom;
    it.tick_word    = $urandom;
    it.byte_count   = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(1, 32));
    return it;
  endfunction

  // Receiver: random stall, plus the long hold-off stretch.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Checker at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h last %b", out_data.random_byte,
                                       out_data.last_byte);
      end else begin
        if (out_data !== digest_bytes_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte %0d: expected %h/%b got %h/%b", bytes_checked,
                     digest_bytes_due[0].random_byte, digest_bytes_due[0].last_byte,
                     out_data.random_byte, out_data.last_byte);
        end
        void'(digest_bytes_due.pop_front());
        bytes_checked++;
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    epse_in_t it;
    for (int i = 0; i < 8; i++) pool_model[i] = '0;
    feeds_seen = '0;
    requests_seen = '0;
    directed_rows = '{
      '{'{OP_EXTRACT, 32'h0, 32'h0, 32'h0, 6'd32}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'h0, 32'hffffffff, 32'hffffffff, 6'd1}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'h0, 32'h12345678, 32'h0, 6'd0}, 1'b0, '0},
      '{'{OP_FEED, 32'h0, 32'h0, 32'h0, 6'd0}, 1'b0, '0},
      '{'{OP_FEED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd63}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'hffffffff, 32'h0, 32'hffffffff, 6'd63}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'h0, 32'haaaaaaaa, 32'h55555555, 6'd33}, 1'b0, '0},
      '{'{OP_FEED, 32'h80000000, 32'h0, 32'h0, 6'd0}, 1'b0, '0},
      '{'{OP_FEED, 32'h00000001, 32'h0, 32'h0, 6'd0}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'h0, 32'h55555555, 32'haaaaaaaa, 6'd31}, 1'b0, '0},
      '{'{OP_EXTRACT, 32'h0, 32'h1, 32'h80000000, 6'd2}, 1'b0, '0}
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part; the hold-off burst doubles as the stall-filling case.
    foreach (directed_rows[r]) send_beat(directed_rows[r].item);
    wait_drained();

    // Sender keeps offering while the receiver holds off for a long stretch.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_beat(random_item(1'b1));
    join
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 23 : 0;
      for (int i = 0; i < 115; i++) begin
        // Mostly feeds with an extract about every third beat.
        it = random_item($urandom_range(2) == 0);
        send_beat(it);
        if (i == 60) wait_drained();
      end
      wait_drained();
    end
    repeat (100) @(negedge clk);
    $display("Covered %0d feeds and %0d extracts, %0d digest bytes checked.",
             feeds_sent, extracts_sent, bytes_checked);
    if (mismatches == 0 && digest_bytes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
